[hdl/pcm_sample_format_converter_unit_defines.svh]
// ----------------------------------------------------------------------------
// PCM sample format converter: assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef PCM_SAMPLE_FORMAT_CONVERTER_UNIT_DEFINES_SVH
`define PCM_SAMPLE_FORMAT_CONVERTER_UNIT_DEFINES_SVH

// Clocked implication, disabled while reset is asserted.
`define PCM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pcm converter check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pcm converter check failed");

`endif

[hdl/pcm_sfc_pkg.sv]
// ----------------------------------------------------------------------------
// PCM sample format converter package
// Format codes, conversion modes and output packing constants.
// ----------------------------------------------------------------------------
`default_nettype none
package pcm_sfc_pkg;

	localparam logic [2:0] SRC_U8  = 3'd0;
	localparam logic [2:0] SRC_S16 = 3'd1;
	localparam logic [2:0] SRC_S24 = 3'd2;
	localparam logic [2:0] SRC_S32 = 3'd3;
	localparam logic [2:0] SRC_F32 = 3'd4;

	localparam logic TGT_S16 = 1'b0;
	localparam logic TGT_F32 = 1'b1;

	localparam logic [7:0] CFG_SOURCE_FORMAT = 8'd0;
	localparam logic [7:0] CFG_TARGET_FORMAT = 8'd1;

	// conversion path chosen per item
	localparam logic [2:0] MODE_ZERO   = 3'd0;
	localparam logic [2:0] MODE_PASS32 = 3'd1;
	localparam logic [2:0] MODE_PASS16 = 3'd2;
	localparam logic [2:0] MODE_I2F    = 3'd3;
	localparam logic [2:0] MODE_I2S    = 3'd4;
	localparam logic [2:0] MODE_F2S    = 3'd5;

	localparam logic [2:0] BYTES_S16 = 3'd2;
	localparam logic [2:0] BYTES_F32 = 3'd4;

	localparam int OUT_W = 40;

endpackage
`default_nettype wire

[hdl/pcm_sample_format_converter_unit.sv]
// Each sample moves through the stage 1 to 4 registers to the master side.
// Throughput: one sample per cycle; per-stage valid bits let bubbles close
// under a stall, and the output register holds a result until it is taken.
// Reset (arst_n low, asynchronous) empties the pipeline and sets
// source_format to s16 and target_format to f32.
// ----------------------------------------------------------------------------
// PCM sample format converter
// Converts u8/s16/s24/s32/f32 samples to s16 or f32 in a 4-stage pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module pcm_sample_format_converter_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] sample_bits
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [pcm_sfc_pkg::OUT_W-1:0] m_tdata // [31:0] result_bits,
	                                              // [34:32] result_bytes,
	                                              // [35] saturated, [39:36] 0
);

	logic [2:0] src_fmt_q;
	logic       tgt_fmt_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_fmt_q <= pcm_sfc_pkg::SRC_S16;
			tgt_fmt_q <= pcm_sfc_pkg::TGT_F32;
		end else if (cfg_valid) begin
			if (cfg_index == pcm_sfc_pkg::CFG_SOURCE_FORMAT) src_fmt_q <= cfg_data[2:0];
			else if (cfg_index == pcm_sfc_pkg::CFG_TARGET_FORMAT) tgt_fmt_q <= cfg_data[0];
		end
	end

	// stage enables: a stage loads when empty or when its successor moves
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;
	assign en4 = !v_s4 || m_tready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// ---------------- stage 1: decode, sign and magnitude ----------------
	logic [2:0]  mode_c;
	logic [32:0] sval_c;
	logic [4:0]  sh_c;
	logic        neg_c;
	logic [31:0] mag_c;

	always_comb begin
		mode_c = pcm_sfc_pkg::MODE_ZERO;
		sval_c = '0;
		sh_c   = 5'd0;
		case (src_fmt_q)
			pcm_sfc_pkg::SRC_U8: begin
				sval_c = {25'd0, s_tdata[7:0]} - 33'd128;
				sh_c   = 5'd7;
			end
			pcm_sfc_pkg::SRC_S16: begin
				sval_c = {{17{s_tdata[15]}}, s_tdata[15:0]};
				sh_c   = 5'd15;
			end
			pcm_sfc_pkg::SRC_S24: begin
				sval_c = {{9{s_tdata[23]}}, s_tdata[23:0]};
				sh_c   = 5'd23;
			end
			pcm_sfc_pkg::SRC_S32: begin
				sval_c = {s_tdata[31], s_tdata};
				sh_c   = 5'd31;
			end
			default: sval_c = {1'b0, s_tdata};
		endcase
		if (src_fmt_q == pcm_sfc_pkg::SRC_F32)
			mode_c = tgt_fmt_q ? pcm_sfc_pkg::MODE_PASS32 : pcm_sfc_pkg::MODE_F2S;
		else if (src_fmt_q > pcm_sfc_pkg::SRC_F32)
			mode_c = pcm_sfc_pkg::MODE_ZERO;
		else if (tgt_fmt_q == pcm_sfc_pkg::TGT_F32)
			mode_c = pcm_sfc_pkg::MODE_I2F;
		else if (src_fmt_q == pcm_sfc_pkg::SRC_S16)
			mode_c = pcm_sfc_pkg::MODE_PASS16;
		else
			mode_c = pcm_sfc_pkg::MODE_I2S;
		neg_c = 1'b0;
		mag_c = s_tdata;
		if (mode_c == pcm_sfc_pkg::MODE_I2F || mode_c == pcm_sfc_pkg::MODE_I2S) begin
			neg_c = sval_c[32];
			mag_c = sval_c[32] ? 32'(-sval_c) : sval_c[31:0];
		end
	end

	logic [2:0]  mode_s1;
	logic        tf_s1, neg_s1;
	logic [4:0]  sh_s1;
	logic [31:0] mag_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			mode_s1 <= mode_c;
			tf_s1   <= tgt_fmt_q;
			neg_s1  <= neg_c;
			sh_s1   <= sh_c;
			mag_s1  <= mag_c;
		end
	end

	// ---------------- stage 2: leading zeros, multiply, float align -------
	logic [4:0]  lz_c;
	logic [46:0] prod_c;
	logic [7:0]  fe_c, fee_c;
	logic [23:0] fm_c;
	logic [7:0]  fsh8_c;
	logic [4:0]  fsh_c;
	logic [49:0] fext_c;
	logic        fnan_c, fbig_c;

	always_comb begin
		lz_c = 5'd0;
		for (int i = 0; i < 32; i++)
			if (mag_s1[i]) lz_c = 5'(31 - i);
		prod_c = {15'd0, mag_s1} * 47'd32767;
		fe_c   = mag_s1[30:23];
		fnan_c = (fe_c == 8'hFF) && (mag_s1[22:0] != 23'd0);
		fbig_c = fe_c >= 8'd135;
		fm_c   = {fe_c != 8'd0, mag_s1[22:0]};
		fee_c  = (fe_c == 8'd0) ? 8'd1 : fe_c;
		fsh8_c = 8'd135 - fee_c;
		fsh_c  = (fbig_c || fsh8_c > 8'd26) ? 5'd26 : fsh8_c[4:0];
		fext_c = {fm_c, 26'd0} >> fsh_c;
	end

	logic [2:0]  mode_s2;
	logic        tf_s2, neg_s2, zero_s2;
	logic [4:0]  sh_s2, lz_s2;
	logic [31:0] mag_s2;
	logic [46:0] prod_s2;
	logic        fnan_s2, fbig_s2, fg_s2, fst_s2;
	logic [23:0] fq_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			mode_s2 <= mode_s1;
			tf_s2   <= tf_s1;
			neg_s2  <= (mode_s1 == pcm_sfc_pkg::MODE_F2S) ? mag_s1[31] : neg_s1;
			zero_s2 <= mag_s1 == 32'd0;
			sh_s2   <= sh_s1;
			lz_s2   <= lz_c;
			mag_s2  <= mag_s1;
			prod_s2 <= prod_c;
			fnan_s2 <= fnan_c;
			fbig_s2 <= fbig_c;
			fq_s2   <= fext_c[49:26];
			fg_s2   <= fext_c[25];
			fst_s2  <= |fext_c[24:0];
		end
	end

	// ---------------- stage 3: normalize, scale and round to integer ------
	logic [31:0] norm_c;
	logic [7:0]  exp_c;
	logic [78:0] pext_c;
	logic [46:0] pq_c;
	logic        prnd_c, frnd_c, sat_c;
	logic [24:0] fmag_c;
	logic [16:0] imag_c;

	always_comb begin
		norm_c = mag_s2 << lz_s2;
		exp_c  = 8'd158 - {3'd0, lz_s2} - {3'd0, sh_s2};
		pext_c = {prod_s2, 32'd0} >> sh_s2;
		pq_c   = pext_c[78:32];
		prnd_c = pext_c[31] && ((|pext_c[30:0]) || pq_c[0]);
		frnd_c = fg_s2 && (fst_s2 || fq_s2[0]);
		fmag_c = {1'b0, fq_s2} + {24'd0, frnd_c};
		sat_c  = 1'b0;
		imag_c = pq_c[16:0] + {16'd0, prnd_c};
		if (mode_s2 == pcm_sfc_pkg::MODE_F2S) begin
			imag_c = fmag_c[16:0];
			sat_c  = fnan_s2 || fbig_s2 ||
				(neg_s2 ? (fmag_c > 25'd32768) : (fmag_c > 25'd32767));
		end
	end

	logic [2:0]  mode_s3;
	logic        tf_s3, neg_s3, zero_s3, nan_s3, sat_s3;
	logic [31:0] norm_s3;
	logic [7:0]  exp_s3;
	logic [16:0] imag_s3;
	logic [31:0] raw_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			mode_s3 <= mode_s2;
			tf_s3   <= tf_s2;
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
			nan_s3  <= fnan_s2;
			sat_s3  <= sat_c;
			norm_s3 <= norm_c;
			exp_s3  <= exp_c;
			imag_s3 <= imag_c;
			raw_s3  <= mag_s2;
		end
	end

	// ---------------- stage 4: pack float, pass through or clamp 16-bit ---
	logic        nrnd_c;
	logic [24:0] nm_c;
	logic [7:0]  nexp_c;
	logic [31:0] bits_c;
	logic        osat_c;
	logic [15:0] s16_c;

	always_comb begin
		nrnd_c = norm_s3[7] && ((|norm_s3[6:0]) || norm_s3[8]);
		nm_c   = {1'b0, norm_s3[31:8]} + {24'd0, nrnd_c};
		nexp_c = nm_c[24] ? exp_s3 + 8'd1 : exp_s3;
		s16_c  = neg_s3 ? 16'(-imag_s3) : imag_s3[15:0];
		osat_c = 1'b0;
		bits_c = 32'd0;
		case (mode_s3)
			pcm_sfc_pkg::MODE_PASS32: bits_c = raw_s3;
			pcm_sfc_pkg::MODE_PASS16: bits_c = {16'd0, raw_s3[15:0]};
			pcm_sfc_pkg::MODE_I2F:
				bits_c = zero_s3 ? 32'd0 :
					{neg_s3, nexp_c, nm_c[24] ? nm_c[23:1] : nm_c[22:0]};
			pcm_sfc_pkg::MODE_I2S: bits_c = {16'd0, s16_c};
			pcm_sfc_pkg::MODE_F2S: begin
				osat_c = sat_s3;
				if (nan_s3) bits_c = 32'd0;
				else if (sat_s3) bits_c = neg_s3 ? 32'h8000 : 32'h7FFF;
				else bits_c = {16'd0, s16_c};
			end
			default: bits_c = 32'd0;
		endcase
	end

	logic [pcm_sfc_pkg::OUT_W-1:0] out_s4;

	always_ff @(posedge clk) begin
		if (en4)
			out_s4 <= {4'd0, osat_c,
				tf_s3 ? pcm_sfc_pkg::BYTES_F32 : pcm_sfc_pkg::BYTES_S16, bits_c};
	end

	assign m_tvalid = v_s4;
	assign m_tdata  = out_s4;

endmodule
`default_nettype wire

[hdl/pcm_sfc_checker.sv]
// ----------------------------------------------------------------------------
// PCM sample format converter port checker
// Checks held valid under a stall and consistent packing of each result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pcm_sample_format_converter_unit_defines.svh"
module pcm_sfc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [pcm_sfc_pkg::OUT_W-1:0] m_tdata
);

	`PCM_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
	`PCM_ASSERT_IMP(a_bytes_code, m_tvalid, (m_tdata[34:32] == pcm_sfc_pkg::BYTES_S16) || (m_tdata[34:32] == pcm_sfc_pkg::BYTES_F32))
	`PCM_ASSERT_IMP(a_float_no_sat, m_tvalid && (m_tdata[34:32] == pcm_sfc_pkg::BYTES_F32), !m_tdata[35])
	`PCM_ASSERT_IMP(a_s16_upper_zero, m_tvalid && (m_tdata[34:32] == pcm_sfc_pkg::BYTES_S16), m_tdata[31:16] == 16'd0)

endmodule

bind pcm_sample_format_converter_unit pcm_sfc_checker u_pcm_sfc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);
`default_nettype wire
